// ----- rtl/bpmf_pkg.sv -----
// Shared types and constants for the byte pattern match finder.
// No dependencies.
package bpmf_pkg;

    localparam int PATTERN_CAP = 16;
    localparam int LEN_BITS    = 5;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 5;
    localparam int REG_IDX_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;

    typedef struct packed {
        logic [63:0]         pattern_low;
        logic [63:0]         pattern_high;
        logic [LEN_BITS-1:0] pat_len;
    } cfg_t;

    // Pattern byte at index idx; bytes beyond the pattern registers read as zero.
    function automatic logic [7:0] pattern_byte(input cfg_t cfg, input logic [7:0] idx);
        logic [127:0] pat;
        pat = {cfg.pattern_high, cfg.pattern_low};
        if (idx < 8'(PATTERN_CAP)) begin
            return pat[{idx[3:0], 3'b000} +: 8];
        end
        return 8'h00;
    endfunction

endpackage

// ----- rtl/bpmf_cfg_regs.sv -----
// APB configuration registers for the byte pattern match finder.
// Depends on bpmf_pkg.
module bpmf_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpmf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bpmf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bpmf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output bpmf_pkg::cfg_t                      cfg
);

    bpmf_pkg::cfg_t                        cfg_reg;
    bpmf_pkg::cfg_t                        cfg_next;
    logic [bpmf_pkg::REG_IDX_W-1:0]        reg_idx;
    logic                                  wr_en;

    assign reg_idx = paddr[bpmf_pkg::APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                bpmf_pkg::REG_PATTERN_LOW:  cfg_next.pattern_low  = pwdata;
                bpmf_pkg::REG_PATTERN_HIGH: cfg_next.pattern_high = pwdata;
                bpmf_pkg::REG_PATTERN_LEN:
                    cfg_next.pat_len = pwdata[bpmf_pkg::LEN_BITS-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bpmf_pkg::REG_PATTERN_LOW:  prdata = cfg_reg.pattern_low;
            bpmf_pkg::REG_PATTERN_HIGH: prdata = cfg_reg.pattern_high;
            bpmf_pkg::REG_PATTERN_LEN:
                prdata = bpmf_pkg::APB_DATA_W'(cfg_reg.pat_len);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_low  <= '0;
            cfg_reg.pattern_high <= '0;
            cfg_reg.pat_len      <= bpmf_pkg::LEN_BITS'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/bpmf_window.sv -----
// Region window state: recent bytes, valid count and saturating region offset.
// Does not depend on bpmf_pkg; all widths are passed in as parameters.
module bpmf_window #(
    parameter int PATTERN_BYTES = 16,
    parameter int OFFSET_BITS   = 32,
    parameter int WIN_BYTES     = 15,
    parameter int LW            = 5
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     update,
    input  logic [7:0]               data_byte,
    input  logic                     last_in_region,
    output logic [WIN_BYTES*8-1:0]   window,
    output logic [LW-1:0]            valid_count,
    output logic [OFFSET_BITS-1:0]   region_offset
);

    logic [WIN_BYTES*8-1:0]  win_reg;
    logic [WIN_BYTES*8-1:0]  win_next;
    logic [LW-1:0]           count_reg;
    logic [LW-1:0]           count_next;
    logic [OFFSET_BITS-1:0]  offset_reg;
    logic [OFFSET_BITS-1:0]  offset_next;
    logic [LW-1:0]           avail;

    assign window        = win_reg;
    assign valid_count   = count_reg;
    assign region_offset = offset_reg;
    assign avail         = count_reg + LW'(1);

    always_comb begin
        win_next    = win_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        if (update) begin
            if (last_in_region) begin
                win_next    = '0;
                count_next  = '0;
                offset_next = '0;
            end else begin
                win_next[7:0] = data_byte;
                for (int k = 1; k < WIN_BYTES; k++) begin
                    win_next[k*8 +: 8] = win_reg[(k-1)*8 +: 8];
                end
                count_next = (avail > LW'(PATTERN_BYTES - 1)) ? LW'(PATTERN_BYTES - 1) : avail;
                if (offset_reg != {OFFSET_BITS{1'b1}}) begin
                    offset_next = offset_reg + OFFSET_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg    <= '0;
            count_reg  <= '0;
            offset_reg <= '0;
        end else begin
            win_reg    <= win_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
        end
    end

endmodule

// ----- rtl/bpmf_matcher.sv -----
// Parallel compare of the current byte and window against the pattern.
// Depends on bpmf_pkg.
module bpmf_matcher #(
    parameter int PATTERN_BYTES = 16,
    parameter int OFFSET_BITS   = 32,
    parameter int WIN_BYTES     = 15,
    parameter int LW            = 5
) (
    input  bpmf_pkg::cfg_t            cfg,
    input  logic [7:0]                data_byte,
    input  logic [WIN_BYTES*8-1:0]    window,
    input  logic [LW-1:0]             valid_count,
    input  logic [OFFSET_BITS-1:0]    region_offset,
    output logic                      hit,
    output logic [31:0]               match_offset
);

    localparam int XW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

    logic [7:0]              cand [PATTERN_BYTES];
    logic [PATTERN_BYTES-1:0] lane_ok;
    logic [LW-1:0]           len_raw;
    logic [LW-1:0]           len_eff;
    logic [LW-1:0]           avail;
    logic [XW-1:0]           diff;

    assign len_raw = LW'(cfg.pat_len);
    assign len_eff = (len_raw == '0) ? LW'(1) :
                     (len_raw > LW'(PATTERN_BYTES)) ? LW'(PATTERN_BYTES) : len_raw;
    assign avail   = valid_count + LW'(1);

    always_comb begin
        cand[0] = data_byte;
        for (int j = 1; j < PATTERN_BYTES; j++) begin
            cand[j] = window[(j-1)*8 +: 8];
        end
    end

    // cand[j] is the byte j positions back; it must equal pattern byte len-1-j
    always_comb begin
        logic [LW-1:0] pidx;
        for (int j = 0; j < PATTERN_BYTES; j++) begin
            pidx       = len_eff - LW'(1) - LW'(j);
            lane_ok[j] = (LW'(j) >= len_eff) ||
                         (cand[j] == bpmf_pkg::pattern_byte(cfg, 8'(pidx)));
        end
    end

    assign hit          = (avail >= len_eff) && (&lane_ok);
    assign diff         = XW'(region_offset) - XW'(len_eff - LW'(1));
    assign match_offset = diff[31:0];

endmodule

// ----- rtl/byte_pattern_match_finder.sv -----
// Top level of the byte pattern match finder: input register, window state,
// matcher and result register. Depends on bpmf_pkg, bpmf_cfg_regs,
// bpmf_window and bpmf_matcher.
//
// Usage:
//   Bytes of a region arrive on the s_ channel (s_data_byte, s_last_in_region)
//   with valid/ready. Each transfer whose byte completes the configured pattern
//   produces one transfer on the m_ channel carrying the region offset of the
//   match's first byte; other bytes produce nothing. Overlapping matches are
//   all reported. The window and offset clear after a byte marked last.
//   The pattern and its length are written over the APB port; the user must write them while idle (not enforced).
//   A byte is held in the input register and its result in the result register.
//   Throughput: one byte per cycle while m_ready does not stall the output, set by the
//   combinational window compare between the input register and the result register.
//   Reset (aresetn low, synchronous) empties both registers, clears the
//   window and offset, and loads pattern length 1 with a zero pattern.
//   When m_ready is low with a result pending, the input register still
//   takes one more byte; after that s_ready drops until the result moves.
module byte_pattern_match_finder #(
    parameter int PATTERN_BYTES = 16,
    parameter int OFFSET_BITS   = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_last_in_region,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [31:0]                         m_match_offset,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpmf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bpmf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bpmf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int WIN_BYTES = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1;
    localparam int LEN_W     = $clog2(PATTERN_BYTES + 1);
    localparam int LW        = (LEN_W > bpmf_pkg::LEN_BITS) ? LEN_W : bpmf_pkg::LEN_BITS;

    bpmf_pkg::cfg_t             cfg;
    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;
    logic                       in_last_reg;
    logic                       out_valid_reg;
    logic [31:0]                out_offset_reg;
    logic                       advance;
    logic                       hit;
    logic [31:0]                match_offset;
    logic [WIN_BYTES*8-1:0]     window;
    logic [LW-1:0]              valid_count;
    logic [OFFSET_BITS-1:0]     region_offset;

    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign m_valid        = out_valid_reg;
    assign m_match_offset = out_offset_reg;

    bpmf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpmf_window #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .OFFSET_BITS   (OFFSET_BITS),
        .WIN_BYTES     (WIN_BYTES),
        .LW            (LW)
    ) u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .update         (advance),
        .data_byte      (in_byte_reg),
        .last_in_region (in_last_reg),
        .window         (window),
        .valid_count    (valid_count),
        .region_offset  (region_offset)
    );

    bpmf_matcher #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .OFFSET_BITS   (OFFSET_BITS),
        .WIN_BYTES     (WIN_BYTES),
        .LW            (LW)
    ) u_matcher (
        .cfg           (cfg),
        .data_byte     (in_byte_reg),
        .window        (window),
        .valid_count   (valid_count),
        .region_offset (region_offset),
        .hit           (hit),
        .match_offset  (match_offset)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_in_region;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= hit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && hit) begin
            out_offset_reg <= match_offset;
        end
    end

endmodule
